// File: src/dde_pkg.sv
// Shared constants, command codes and control types of the deadlock detection engine.
package dde_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;
    localparam int COUNT_WIDTH   = 16;
    localparam int AVAIL_WIDTH   = COUNT_WIDTH + 4;

    localparam int PROC_IDX_W = $clog2(MAX_PROCESSES);
    localparam int RES_IDX_W  = $clog2(MAX_RESOURCES);
    localparam int MEM_ADDR_W = PROC_IDX_W + RES_IDX_W;
    localparam int MEM_DEPTH  = MAX_PROCESSES * MAX_RESOURCES;

    localparam int PCNT_W = 5;
    localparam int RCNT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [PCNT_W-1:0] NP_MAX = PCNT_W'(MAX_PROCESSES);
    localparam logic [RCNT_W-1:0] NR_MAX = RCNT_W'(MAX_RESOURCES);

    localparam logic [1:0] CMD_LOAD_AVAIL = 2'd0;
    localparam logic [1:0] CMD_LOAD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_LOAD_NEED  = 2'd2;
    localparam logic [1:0] CMD_START      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 2'd1;

    typedef struct packed {
        logic load;
        logic start;
        logic pass_restart;
        logic p_inc;
        logic r_clr;
        logic r_inc;
        logic add;
        logic emit;
        logic final_push;
        logic final_dead;
    } t_dp_cmd;

    typedef struct packed {
        logic rem_zero;
        logic p_end;
        logic progress;
        logic mark;
        logic r_end;
        logic need_fits;
        logic out_free;
    } t_dp_stat;

endpackage

// File: src/dde_if.sv
// Handshake channels of the deadlock detection engine: input items, results, configuration.
interface dde_in_if;
    import dde_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [PROC_IDX_W-1:0]      proc_index;
    logic [RES_IDX_W-1:0]       res_index;
    logic [COUNT_WIDTH-1:0]     amount;

    modport source (output valid, cmd, proc_index, res_index, amount, input ready);
    modport sink   (input valid, cmd, proc_index, res_index, amount, output ready);
endinterface

interface dde_out_if;
    import dde_pkg::*;
    logic              valid;
    logic              ready;
    logic [PCNT_W-1:0] finished_process;
    logic              deadlock;
    logic              last;

    modport source (output valid, finished_process, deadlock, last, input ready);
    modport sink   (input valid, finished_process, deadlock, last, output ready);
endinterface

interface dde_cfg_if;
    import dde_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/dde_datapath.sv
// Datapath: configuration, available vector, allocation and need memories, counters, result register.
module dde_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [dde_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dde_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                       i_cmd,
    input  logic [dde_pkg::PROC_IDX_W-1:0]   i_proc_index,
    input  logic [dde_pkg::RES_IDX_W-1:0]    i_res_index,
    input  logic [dde_pkg::COUNT_WIDTH-1:0]  i_amount,
    input  dde_pkg::t_dp_cmd                 i_ctl,
    output dde_pkg::t_dp_stat                o_stat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dde_pkg::PCNT_W-1:0]       o_finished_process,
    output logic                             o_deadlock,
    output logic                             o_last
);
    import dde_pkg::*;

    logic [PCNT_W-1:0]      r_process_count;
    logic [RCNT_W-1:0]      r_resource_count;
    logic [PCNT_W-1:0]      r_np;
    logic [RCNT_W-1:0]      r_nr;
    logic [PCNT_W-1:0]      r_p;
    logic [RCNT_W-1:0]      r_r;
    logic [PCNT_W-1:0]      r_remaining;
    logic                   r_progress;
    logic [MAX_PROCESSES-1:0] r_marks;
    logic [AVAIL_WIDTH-1:0] r_avail [MAX_RESOURCES];
    logic [COUNT_WIDTH-1:0] r_alloc_mem [MEM_DEPTH];
    logic [COUNT_WIDTH-1:0] r_need_mem  [MEM_DEPTH];
    logic [COUNT_WIDTH-1:0] r_alloc_q;
    logic [COUNT_WIDTH-1:0] r_need_q;
    logic                   r_out_valid;
    logic [PCNT_W-1:0]      r_out_proc;
    logic                   r_out_dead;
    logic                   r_out_last;

    logic [PCNT_W-1:0]      np_clamped;
    logic [RCNT_W-1:0]      nr_clamped;
    logic [MEM_ADDR_W-1:0]  rd_addr;
    logic [MEM_ADDR_W-1:0]  wr_addr;
    logic [RES_IDX_W-1:0]   r_sel;
    logic [AVAIL_WIDTH:0]   sum;
    logic [AVAIL_WIDTH-1:0] n_avail_sum;
    logic                   out_free;

    assign np_clamped = (r_process_count > NP_MAX) ? NP_MAX : r_process_count;
    assign nr_clamped = (r_resource_count > NR_MAX) ? NR_MAX : r_resource_count;
    assign r_sel      = r_r[RES_IDX_W-1:0];
    assign rd_addr    = {r_p[PROC_IDX_W-1:0], r_sel};
    assign wr_addr    = {i_proc_index, i_res_index};
    assign sum        = {1'b0, r_avail[r_sel]} + (AVAIL_WIDTH + 1)'(r_alloc_q);
    // Returned instances saturate rather than wrap.
    assign n_avail_sum = sum[AVAIL_WIDTH] ? {AVAIL_WIDTH{1'b1}} : sum[AVAIL_WIDTH-1:0];
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_stat.rem_zero  = (r_remaining == '0);
    assign o_stat.p_end     = (r_p == r_np);
    assign o_stat.progress  = r_progress;
    assign o_stat.mark      = r_marks[r_p[PROC_IDX_W-1:0]];
    assign o_stat.r_end     = (r_r == r_nr);
    assign o_stat.need_fits = (r_avail[r_sel] >= AVAIL_WIDTH'(r_need_q));
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_count  <= '0;
            r_resource_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PROCESS_COUNT:  r_process_count  <= i_cfg_data;
                REG_RESOURCE_COUNT: r_resource_count <= i_cfg_data[RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Memories: one write port for loads, registered reads at the current process and resource.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_cmd == CMD_LOAD_ALLOC) begin
            r_alloc_mem[wr_addr] <= i_amount;
        end
        if (i_ctl.load && i_cmd == CMD_LOAD_NEED) begin
            r_need_mem[wr_addr] <= i_amount;
        end
        r_alloc_q <= r_alloc_mem[rd_addr];
        r_need_q  <= r_need_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                r_avail[i] <= '0;
            end
        end else if (i_ctl.load && i_cmd == CMD_LOAD_AVAIL) begin
            r_avail[i_res_index] <= AVAIL_WIDTH'(i_amount);
        end else if (i_ctl.add) begin
            r_avail[r_sel] <= n_avail_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np        <= '0;
            r_nr        <= '0;
            r_p         <= '0;
            r_r         <= '0;
            r_remaining <= '0;
            r_progress  <= 1'b0;
            r_marks     <= '0;
        end else begin
            if (i_ctl.start) begin
                r_np        <= np_clamped;
                r_nr        <= nr_clamped;
                r_p         <= '0;
                r_remaining <= np_clamped;
                r_progress  <= 1'b0;
                r_marks     <= '0;
            end
            if (i_ctl.pass_restart) begin
                r_p        <= '0;
                r_progress <= 1'b0;
            end
            if (i_ctl.p_inc) begin
                r_p <= r_p + 1'b1;
            end
            if (i_ctl.emit) begin
                r_marks[r_p[PROC_IDX_W-1:0]] <= 1'b1;
                r_remaining <= r_remaining - 1'b1;
                r_progress  <= 1'b1;
                r_p         <= r_p + 1'b1;
            end
            if (i_ctl.r_clr) begin
                r_r <= '0;
            end else if (i_ctl.r_inc) begin
                r_r <= r_r + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit || i_ctl.final_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_proc <= r_p + 1'b1;
            r_out_dead <= 1'b0;
            r_out_last <= 1'b0;
        end else if (i_ctl.final_push) begin
            r_out_proc <= '0;
            r_out_dead <= i_ctl.final_dead;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_finished_process = r_out_proc;
    assign o_deadlock         = r_out_dead;
    assign o_last             = r_out_last;

`ifndef SYNTHESIS
    a_remaining_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= r_np)
        else $error("remaining count exceeds process count");
    a_emit_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.emit || i_ctl.final_push) |-> out_free)
        else $error("result pushed over an unread result");
`endif
endmodule

// File: src/dde_ctrl.sv
// Controller: sequences loads, passes over processes, resource compares and give-backs.
module dde_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_cmd,
    output logic               o_in_ready,
    input  dde_pkg::t_dp_stat  i_stat,
    output dde_pkg::t_dp_cmd   o_ctl
);
    import dde_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSEL   = 4'd1;
    localparam logic [3:0] S_NRD    = 4'd2;
    localparam logic [3:0] S_NCMP   = 4'd3;
    localparam logic [3:0] S_ARD    = 4'd4;
    localparam logic [3:0] S_ADD    = 4'd5;
    localparam logic [3:0] S_EMIT   = 4'd6;
    localparam logic [3:0] S_FIN_OK = 4'd7;
    localparam logic [3:0] S_FIN_DL = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_START) begin
                        o_ctl.start = 1'b1;
                        n_state     = S_PSEL;
                    end else begin
                        o_ctl.load = 1'b1;
                    end
                end
            end
            S_PSEL: begin
                if (i_stat.rem_zero) begin
                    n_state = S_FIN_OK;
                end else if (i_stat.p_end) begin
                    // A pass that finished nobody means the rest are stuck.
                    if (i_stat.progress) begin
                        o_ctl.pass_restart = 1'b1;
                    end else begin
                        n_state = S_FIN_DL;
                    end
                end else if (i_stat.mark) begin
                    o_ctl.p_inc = 1'b1;
                end else begin
                    o_ctl.r_clr = 1'b1;
                    n_state     = S_NRD;
                end
            end
            S_NRD: begin
                if (i_stat.r_end) begin
                    o_ctl.r_clr = 1'b1;
                    n_state     = S_ARD;
                end else begin
                    n_state = S_NCMP;
                end
            end
            S_NCMP: begin
                if (i_stat.need_fits) begin
                    o_ctl.r_inc = 1'b1;
                    n_state     = S_NRD;
                end else begin
                    o_ctl.p_inc = 1'b1;
                    n_state     = S_PSEL;
                end
            end
            S_ARD: begin
                n_state = i_stat.r_end ? S_EMIT : S_ADD;
            end
            S_ADD: begin
                o_ctl.add   = 1'b1;
                o_ctl.r_inc = 1'b1;
                n_state     = S_ARD;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_PSEL;
                end
            end
            S_FIN_OK, S_FIN_DL: begin
                if (i_stat.out_free) begin
                    o_ctl.final_push = 1'b1;
                    o_ctl.final_dead = (r_state == S_FIN_DL);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NCMP) |-> ($past(r_state) == S_NRD))
        else $error("need compare without a preceding memory read");
    a_add_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ($past(r_state) == S_ARD))
        else $error("give-back without a preceding memory read");
    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.final_push |=> (r_state == S_IDLE))
        else $error("status item not followed by idle");
    a_single_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.emit && o_ctl.final_push))
        else $error("two results pushed in one cycle");
`endif
endmodule

// File: src/deadlock_detection_engine_unit.sv
// Top level of the deadlock detection engine: controller, datapath and channel wiring.
//
// Load items (available, allocation, need) are taken one per cycle while the engine
// is idle and return nothing. A start item runs the check on one need/allocation
// entry at a time, since both matrices sit in single-read-port memories: per pass, a
// finished process is skipped, an unfinished one has its need compared resource by
// resource up to the first that does not fit, and a process that fits has all R
// resources compared, its allocation given back, and its item emitted, R being the
// resource count in use. A check makes at most P passes over P processes, then pushes
// the status item; the input is held off until that status item is in the output
// register. The output register lets the check go on while an item waits to be taken;
// a stalled output only stops the engine when it has the next item ready.
// No clearing pass is needed.
module deadlock_detection_engine_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dde_in_if.sink     i_in,
    dde_cfg_if.sink    i_cfg,
    dde_out_if.source  o_out
);
    import dde_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    dde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_cmd      (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    dde_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg.valid),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .i_cmd              (i_in.cmd),
        .i_proc_index       (i_in.proc_index),
        .i_res_index        (i_in.res_index),
        .i_amount           (i_in.amount),
        .i_ctl              (ctl),
        .o_stat             (stat),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_finished_process (o_out.finished_process),
        .o_deadlock         (o_out.deadlock),
        .o_last             (o_out.last)
    );
endmodule
